[rtl/core/nalsp_pkg.sv]
// Shared types and constants of the Annex B NAL unit splitter.
package nalsp_pkg;

    localparam int FIELD_W = 24;  // offset and length field width
    localparam int INDEX_W = 8;   // unit index field width
    localparam int HIST_W = 32;   // last four bytes
    localparam int SINCE_W = 3;   // bytes since header counter

    localparam logic [23:0] START_CODE = 24'h000001;
    localparam logic [SINCE_W-1:0] SINCE_MIN_SHORT = 3'd3;
    localparam logic [SINCE_W-1:0] SINCE_MIN_LONG = 3'd4;
    localparam logic [SINCE_W-1:0] SINCE_SAT = 3'd7;
    localparam int SHORT_CODE_BYTES = 3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [FIELD_W-1:0] unit_offset;
        logic [FIELD_W-1:0] unit_length;
        logic               long_start_code;
        logic [INDEX_W-1:0] unit_index;
        logic               index_overflow;
        logic               final_unit;
    } t_result;

    // Up to two results per byte: a closed unit, then the unit closed by the last byte.
    typedef struct packed {
        logic    closed_valid;
        logic    final_valid;
        t_result closed_res;
        t_result final_res;
    } t_push;

endpackage

[rtl/core/nalsp_in_if.sv]
// Byte request channel of the NAL unit splitter.
interface nalsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/core/nalsp_out_if.sv]
// Unit descriptor request channel of the NAL unit splitter.
interface nalsp_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] unit_offset;
    logic [23:0] unit_length;
    logic        long_start_code;
    logic [7:0]  unit_index;
    logic        index_overflow;
    logic        final_unit;

    modport source (output valid, output unit_offset, output unit_length,
                    output long_start_code, output unit_index,
                    output index_overflow, output final_unit, input ready);
    modport sink (input valid, input unit_offset, input unit_length,
                  input long_start_code, input unit_index,
                  input index_overflow, input final_unit, output ready);
endinterface

[rtl/core/nalsp_parser.sv]
// Start code detector and unit tracker: one byte per cycle while i_accept is high.
module nalsp_parser #(
    parameter int OFFSET_BITS = 24,
    parameter int MAX_UNITS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output nalsp_pkg::t_push     o_push
);
    import nalsp_pkg::*;

    localparam int CNT_W = $clog2(MAX_UNITS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_UNITS);
    localparam logic [CNT_W-1:0] IDX_LAST = CNT_W'(MAX_UNITS - 1);
    localparam logic [OFFSET_BITS-1:0] CODE3 = OFFSET_BITS'(SHORT_CODE_BYTES);
    localparam logic [OFFSET_BITS-1:0] ONE_POS = OFFSET_BITS'(1);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    function automatic logic [FIELD_W-1:0] to_field(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+FIELD_W-1:0] w;
        w = {{FIELD_W{1'b0}}, v};
        return w[FIELD_W-1:0];
    endfunction

    function automatic logic [INDEX_W-1:0] to_index(input logic [CNT_W-1:0] v);
        logic [CNT_W+INDEX_W-1:0] w;
        w = {{INDEX_W{1'b0}}, v};
        return w[INDEX_W-1:0];
    endfunction

    logic [HIST_W-1:0]      r_hist, n_hist;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [SINCE_W-1:0]     r_since, n_since;
    logic                   r_open, n_open;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic                   r_long, n_long;
    logic [CNT_W-1:0]       r_cnt, n_cnt;

    logic                   hit, lng, ovf0, ovf1, emit0, emit1;
    logic [OFFSET_BITS-1:0] code_start, start1;
    logic                   open1, long1;
    logic [CNT_W-1:0]       cnt1, cnt2;

    always_comb begin
        hit = (r_since >= SINCE_MIN_SHORT) && (r_hist[23:0] == START_CODE);
        // Long code needs a zero byte before it that lies inside this unit's span.
        lng = (r_open || (r_since >= SINCE_MIN_LONG)) && (r_hist[31:24] == 8'h00);
        code_start = r_pos - CODE3 - OFFSET_BITS'(lng);

        emit0 = hit && r_open;
        open1 = hit || r_open;
        start1 = hit ? code_start : r_start;
        long1 = hit ? lng : r_long;
        emit1 = i_last_byte && open1;

        ovf0 = (r_cnt >= CNT_MAX);
        cnt1 = (emit0 && !ovf0) ? r_cnt + ONE_CNT : r_cnt;
        ovf1 = (cnt1 >= CNT_MAX);
        cnt2 = (emit1 && !ovf1) ? cnt1 + ONE_CNT : cnt1;

        o_push.closed_valid = i_accept && emit0;
        o_push.closed_res.unit_offset = to_field(r_start);
        o_push.closed_res.unit_length = to_field(code_start - r_start);
        o_push.closed_res.long_start_code = r_long;
        o_push.closed_res.unit_index = to_index(ovf0 ? IDX_LAST : r_cnt);
        o_push.closed_res.index_overflow = ovf0;
        o_push.closed_res.final_unit = 1'b0;

        o_push.final_valid = i_accept && emit1;
        o_push.final_res.unit_offset = to_field(start1);
        o_push.final_res.unit_length = to_field(r_pos + ONE_POS - start1);
        o_push.final_res.long_start_code = long1;
        o_push.final_res.unit_index = to_index(ovf1 ? IDX_LAST : cnt1);
        o_push.final_res.index_overflow = ovf1;
        o_push.final_res.final_unit = 1'b1;

        n_hist = r_hist;
        n_pos = r_pos;
        n_since = r_since;
        n_open = r_open;
        n_start = r_start;
        n_long = r_long;
        n_cnt = r_cnt;
        if (i_accept) begin
            if (i_last_byte) begin
                n_hist = '0;
                n_pos = '0;
                n_since = '0;
                n_open = 1'b0;
                n_start = '0;
                n_long = 1'b0;
                n_cnt = '0;
            end else begin
                n_hist = {r_hist[HIST_W-9:0], i_data_byte};
                n_pos = r_pos + ONE_POS;
                if (hit) begin
                    n_since = '0;
                end else if (r_since < SINCE_SAT) begin
                    n_since = r_since + 3'd1;
                end
                n_open = open1;
                n_start = start1;
                n_long = long1;
                n_cnt = cnt2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_pos <= '0;
            r_since <= '0;
            r_open <= 1'b0;
            r_start <= '0;
            r_long <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_hist <= n_hist;
            r_pos <= n_pos;
            r_since <= n_since;
            r_open <= n_open;
            r_start <= n_start;
            r_long <= n_long;
            r_cnt <= n_cnt;
        end
    end
endmodule

[rtl/core/nalsp_fifo.sv]
// Result queue: takes up to two descriptors a cycle, gives one per pop.
module nalsp_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  nalsp_pkg::t_push     i_push,
    input  logic                 i_pop,
    output nalsp_pkg::t_result   o_head,
    output logic                 o_not_empty,
    output logic                 o_room2
);
    import nalsp_pkg::*;

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr, n_wr, r_rd, n_rd;
    logic [FIFO_CNT_W-1:0]  r_cnt, n_cnt;
    logic                   do_pop, two;
    logic [1:0]             n_push;
    t_result                first_res;

    always_comb begin
        do_pop = i_pop && (r_cnt != '0);
        two = i_push.closed_valid && i_push.final_valid;
        n_push = {1'b0, i_push.closed_valid} + {1'b0, i_push.final_valid};
        first_res = i_push.closed_valid ? i_push.closed_res : i_push.final_res;
        n_wr = r_wr + FIFO_PTR_W'(n_push);
        n_rd = r_rd + FIFO_PTR_W'(do_pop);
        n_cnt = r_cnt + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(do_pop);
        o_head = r_mem[r_rd];
        o_not_empty = (r_cnt != '0);
        o_room2 = (r_cnt <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    end

    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_mem[r_wr] <= first_res;
        end
        if (two) begin
            r_mem[r_wr + FIFO_PTR_W'(1)] <= i_push.final_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
    end
endmodule

[rtl/core/annexb_nal_unit_splitter.sv]
// Top level of the Annex B start code NAL unit splitter.
//
//  channel | dir | payload                                        | done when
//  i_in    | in  | data_byte, last_byte                           | valid & ready
//  o_out   | out | unit_offset, unit_length, long_start_code,     | valid & ready
//          |     | unit_index, index_overflow, final_unit         |
//
// One byte is taken per cycle while i_in.ready is high, i.e. while the four-entry queue
// has two free slots; its descriptors enter the result queue at the same edge and show
// on o_out once they reach its head. A byte can close two units (the previous one and,
// on the last byte, the open one); o_out drains one descriptor per cycle while
// o_out.ready is high. A stalled sink thus stops intake once three descriptors wait.
// Synchronous active-low reset clears the parser state and empties the queue.
module annexb_nal_unit_splitter #(
    parameter int OFFSET_BITS = 24,
    parameter int MAX_UNITS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    nalsp_in_if.sink     i_in,
    nalsp_out_if.source  o_out
);
    import nalsp_pkg::*;

    logic    accept;
    logic    room2;
    logic    not_empty;
    t_push   push;
    t_result head;

    // Intake is gated only by queue space, never by pending output.
    assign i_in.ready = room2;
    assign accept = i_in.valid && room2;

    nalsp_parser #(
        .OFFSET_BITS (OFFSET_BITS),
        .MAX_UNITS   (MAX_UNITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_push      (push)
    );

    // Queue keeps the closed unit ahead of the final one when both come together.
    nalsp_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop       (o_out.ready),
        .o_head      (head),
        .o_not_empty (not_empty),
        .o_room2     (room2)
    );

    assign o_out.valid = not_empty;
    assign o_out.unit_offset = head.unit_offset;
    assign o_out.unit_length = head.unit_length;
    assign o_out.long_start_code = head.long_start_code;
    assign o_out.unit_index = head.unit_index;
    assign o_out.index_overflow = head.index_overflow;
    assign o_out.final_unit = head.final_unit;
endmodule

[rtl/core/nalsp_checker.sv]
// Port-level checks of the NAL unit splitter and their binding.
module nalsp_checker #(
    parameter int MAX_UNITS = 256
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_unit_index,
    input logic       i_index_overflow,
    input logic       i_final_unit
);
    localparam logic [7:0] SAT_INDEX = 8'(MAX_UNITS - 1);

    logic       out_acc;
    logic       r_seen;
    logic       r_prev_fin;
    logic       r_prev_ovf;
    logic [7:0] r_prev_idx;

    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_prev_fin <= 1'b0;
            r_prev_ovf <= 1'b0;
            r_prev_idx <= '0;
        end else if (out_acc) begin
            r_seen <= 1'b1;
            r_prev_fin <= i_final_unit;
            r_prev_ovf <= i_index_overflow;
            r_prev_idx <= i_unit_index;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    a_new_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_seen && r_prev_fin |-> i_unit_index == 8'd0 && !i_index_overflow)
        else $error("packet does not restart at unit zero");

    a_next_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_seen && !r_prev_fin && !r_prev_ovf
        |-> i_unit_index == r_prev_idx + 8'd1 || i_index_overflow)
        else $error("unit index skipped");

    a_sat_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_index_overflow |-> i_unit_index == SAT_INDEX)
        else $error("overflowed index not saturated");
endmodule

bind annexb_nal_unit_splitter nalsp_checker #(
    .MAX_UNITS (MAX_UNITS)
) u_nalsp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_unit_index     (o_out.unit_index),
    .i_index_overflow (o_out.index_overflow),
    .i_final_unit     (o_out.final_unit)
);
